### design/sbpc_pkg.sv
// ----------------------------------------------------------------------------
// sbpc_pkg
// Shared constants, codes and types for the shared buffer pipe controller.
// ----------------------------------------------------------------------------
package sbpc_pkg;

  localparam int DEPTH  = 4096;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int PTR_W  = $clog2(DEPTH + 1);
  localparam int LIM_W  = 13;

  localparam logic [PTR_W-1:0] DEPTH_P = PTR_W'(DEPTH);
  localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(4096);

  // pipe states
  localparam logic [2:0] PS_IDLE       = 3'd0;
  localparam logic [2:0] PS_EMPTY_WAIT = 3'd1;
  localparam logic [2:0] PS_FULL_WAIT  = 3'd2;
  localparam logic [2:0] PS_WR_DONE    = 3'd3;
  localparam logic [2:0] PS_RD_DONE    = 3'd4;
  localparam logic [2:0] PS_CLOSED     = 3'd5;

  // operations
  localparam logic [2:0] FN_WRITE   = 3'd0;
  localparam logic [2:0] FN_READ    = 3'd1;
  localparam logic [2:0] FN_CLOSE_W = 3'd2;
  localparam logic [2:0] FN_CLOSE_R = 3'd3;
  localparam logic [2:0] FN_QUERY_W = 3'd4;
  localparam logic [2:0] FN_QUERY_R = 3'd5;
  localparam logic [2:0] FN_EXIT_W  = 3'd6;
  localparam logic [2:0] FN_EXIT_R  = 3'd7;

  // result status
  localparam logic [1:0] ST_COMPLETED = 2'd0;
  localparam logic [1:0] ST_BLOCKED   = 2'd1;
  localparam logic [1:0] ST_DISCARDED = 2'd2;
  localparam logic [1:0] ST_ABORT     = 2'd3;

  typedef struct packed {
    logic load_op;
    logic exec;
    logic load_out;
  } sbpc_cmd_t;

endpackage

### design/sbpc_in_if.sv
// ----------------------------------------------------------------------------
// sbpc_in_if
// Operation request channel: valid/ready with operation payload.
// ----------------------------------------------------------------------------
interface sbpc_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [7:0] wr_byte;
  logic       arm;

  modport source (output valid, output func, output wr_byte, output arm, input ready);
  modport sink   (input valid, input func, input wr_byte, input arm, output ready);
endinterface

### design/sbpc_out_if.sv
// ----------------------------------------------------------------------------
// sbpc_out_if
// Result channel: valid/ready with status and buffer occupancy payload.
// ----------------------------------------------------------------------------
interface sbpc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  rd_byte;
  logic        moved;
  logic [2:0]  prior_state;
  logic [2:0]  post_state;
  logic        peer_wakeup;
  logic [12:0] pending;
  logic [12:0] space;

  modport source (output valid, output status, output rd_byte, output moved,
                  output prior_state, output post_state, output peer_wakeup,
                  output pending, output space, input ready);
  modport sink   (input valid, input status, input rd_byte, input moved,
                  input prior_state, input post_state, input peer_wakeup,
                  input pending, input space, output ready);
endinterface

### design/sbpc_ctrl.sv
// ----------------------------------------------------------------------------
// sbpc_ctrl
// Sequencer: takes a request, runs it through the datapath, then hands the
// result to the output register once that register is free.
// ----------------------------------------------------------------------------
module sbpc_ctrl
  import sbpc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output sbpc_cmd_t cmd
);

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_EXEC = 2'd1;
  localparam logic [1:0] C_FIN  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == C_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      C_IDLE: begin
        if (in_valid) begin
          cmd.load_op = 1'b1;
          state_nxt   = C_EXEC;
        end
      end
      C_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = C_FIN;
      end
      C_FIN: begin
        // result waits here while the previous one is still unclaimed
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = C_IDLE;
        end
      end
      default: begin
        state_nxt = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= C_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### design/sbpc_dp.sv
// ----------------------------------------------------------------------------
// sbpc_dp
// Datapath: pipe state, positions, presence bits, byte store, limit register
// and the result registers.
// ----------------------------------------------------------------------------
module sbpc_dp
  import sbpc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  sbpc_cmd_t        cmd,
  input  logic [2:0]       in_func,
  input  logic [7:0]       in_wr_byte,
  input  logic             in_arm,
  input  logic             cfg_we,
  input  logic [LIM_W-1:0] cfg_wdata,
  output logic [1:0]       out_status,
  output logic [7:0]       out_rd_byte,
  output logic             out_moved,
  output logic [2:0]       out_prior_state,
  output logic [2:0]       out_post_state,
  output logic             out_peer_wakeup,
  output logic [12:0]      out_pending,
  output logic [12:0]      out_space
);

  logic [LIM_W-1:0] limit_r;
  logic [2:0]       pstate_r, pstate_nxt;
  logic [PTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic             wpres_r, wpres_nxt, rpres_r, rpres_nxt;

  logic [2:0]       op_func_r;
  logic [7:0]       op_byte_r;
  logic             op_arm_r;

  logic [7:0]       mem [DEPTH];
  logic [7:0]       mem_q_r;
  logic             mem_we, mem_re;
  logic [ADDR_W-1:0] mem_addr;

  logic [PTR_W-1:0] lim, space_cur, pend_cur, rp_inc;

  logic [1:0]       status;
  logic             moved, wake, go, is_query, as_writer;
  logic [2:0]       partial;

  logic [1:0]       res_status_r;
  logic             res_moved_r, res_read_r, res_wake_r, res_query_r;
  logic [2:0]       res_enter_r;
  logic [PTR_W-1:0] res_pend_r, res_space_r;

  assign lim       = (PTR_W'(limit_r) > DEPTH_P) ? DEPTH_P : PTR_W'(limit_r);
  assign space_cur = (wp_r < lim) ? lim - wp_r : '0;
  assign pend_cur  = (wp_r >= rp_r) ? wp_r - rp_r : '0;
  assign rp_inc    = rp_r + PTR_W'(1);
  assign is_query  = (op_func_r == FN_QUERY_W) || (op_func_r == FN_QUERY_R);
  assign as_writer = (op_func_r == FN_CLOSE_W) || (op_func_r == FN_EXIT_W);
  assign partial   = as_writer ? PS_WR_DONE : PS_RD_DONE;
  assign mem_addr  = (op_func_r == FN_WRITE) ? wp_r[ADDR_W-1:0] : rp_r[ADDR_W-1:0];

  always_comb begin
    pstate_nxt = pstate_r;
    wp_nxt     = wp_r;
    rp_nxt     = rp_r;
    wpres_nxt  = wpres_r;
    rpres_nxt  = rpres_r;
    status     = ST_COMPLETED;
    moved      = 1'b0;
    wake       = 1'b0;
    go         = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    case (op_func_r)
      FN_WRITE: begin
        if (pstate_r == PS_IDLE || pstate_r == PS_EMPTY_WAIT) begin
          if (space_cur == '0) begin
            pstate_nxt = PS_FULL_WAIT;
            status     = ST_BLOCKED;
          end else begin
            pstate_nxt = PS_IDLE;
            go         = 1'b1;
          end
        end else if (pstate_r == PS_FULL_WAIT) begin
          status = ST_BLOCKED;
        end else if (pstate_r == PS_WR_DONE || pstate_r == PS_RD_DONE) begin
          status = ST_DISCARDED;
        end else begin
          status = ST_ABORT;
        end
        if (go && wp_r < DEPTH_P) begin
          mem_we = 1'b1;
          wp_nxt = wp_r + PTR_W'(1);
          moved  = 1'b1;
        end
        wake = (status == ST_COMPLETED) && (pstate_r == PS_EMPTY_WAIT);
      end
      FN_READ: begin
        if (pstate_r == PS_IDLE) begin
          if (pend_cur == '0) begin
            pstate_nxt = PS_EMPTY_WAIT;
            status     = ST_BLOCKED;
          end else begin
            go = 1'b1;
          end
        end else if (pstate_r == PS_EMPTY_WAIT) begin
          status = wpres_r ? ST_BLOCKED : ST_DISCARDED;
        end else if (pstate_r == PS_FULL_WAIT) begin
          if (pend_cur == '0) pstate_nxt = PS_IDLE;
          else go = 1'b1;
        end else if (pstate_r == PS_WR_DONE) begin
          if (pend_cur == '0) status = ST_DISCARDED;
          else go = 1'b1;
        end else begin
          status = ST_ABORT;
        end
        if (go && rp_r < DEPTH_P) begin
          mem_re = 1'b1;
          moved  = 1'b1;
          rp_nxt = rp_inc;
          // drained: both positions rewind
          if (rp_inc == wp_r) begin
            rp_nxt = '0;
            wp_nxt = '0;
            if (!wpres_r) pstate_nxt = PS_WR_DONE;
          end
        end
        wake = (status == ST_COMPLETED) && (pstate_r == PS_FULL_WAIT) &&
               (pstate_nxt == PS_IDLE);
      end
      FN_CLOSE_W, FN_CLOSE_R: begin
        pstate_nxt = partial;
        if (as_writer && pstate_r == PS_RD_DONE)
          pstate_nxt = PS_CLOSED;
        if (!as_writer && pstate_r == PS_WR_DONE)
          pstate_nxt = PS_CLOSED;
        if (pstate_r == PS_FULL_WAIT && !as_writer && wpres_r)
          wake = 1'b1;
        else if (pstate_r == PS_EMPTY_WAIT && as_writer && rpres_r)
          wake = 1'b1;
      end
      FN_QUERY_W, FN_QUERY_R: begin
        if (pstate_r == PS_IDLE && op_arm_r) begin
          if (op_func_r == FN_QUERY_W && space_cur == '0) begin
            pstate_nxt = PS_FULL_WAIT;
          end else if (op_func_r == FN_QUERY_R && pend_cur == '0) begin
            rp_nxt     = '0;
            wp_nxt     = '0;
            pstate_nxt = PS_EMPTY_WAIT;
          end
        end
      end
      default: begin
        if (as_writer) wpres_nxt = 1'b0;
        else rpres_nxt = 1'b0;
        case (pstate_r)
          PS_IDLE: begin
            pstate_nxt = partial;
          end
          PS_EMPTY_WAIT: begin
            pstate_nxt = partial;
            wake       = as_writer;
          end
          PS_FULL_WAIT: begin
            pstate_nxt = partial;
            wake       = !as_writer;
          end
          PS_WR_DONE, PS_RD_DONE: begin
            if (pstate_r != partial) pstate_nxt = PS_CLOSED;
          end
          default: begin
            pstate_nxt = pstate_r;
          end
        endcase
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= LIMIT_RESET;
      pstate_r <= PS_IDLE;
      wp_r     <= '0;
      rp_r     <= '0;
      wpres_r  <= 1'b1;
      rpres_r  <= 1'b1;
    end else begin
      if (cfg_we) limit_r <= cfg_wdata;
      if (cmd.exec) begin
        pstate_r <= pstate_nxt;
        wp_r     <= wp_nxt;
        rp_r     <= rp_nxt;
        wpres_r  <= wpres_nxt;
        rpres_r  <= rpres_nxt;
      end
    end
  end

  // byte store, one access per request
  always_ff @(posedge clk) begin
    if (cmd.exec && mem_we) mem[mem_addr] <= op_byte_r;
    if (cmd.exec && mem_re) mem_q_r <= mem[mem_addr];
  end

  // operation and result registers
  always_ff @(posedge clk) begin
    if (cmd.load_op) begin
      op_func_r <= in_func;
      op_byte_r <= in_wr_byte;
      op_arm_r  <= in_arm;
    end
    if (cmd.exec) begin
      res_status_r <= status;
      res_moved_r  <= moved;
      res_read_r   <= mem_re;
      res_wake_r   <= wake;
      res_enter_r  <= pstate_r;
      res_query_r  <= is_query;
      res_pend_r   <= pend_cur;
      res_space_r  <= space_cur;
    end
    if (cmd.load_out) begin
      out_status      <= res_status_r;
      out_rd_byte     <= res_read_r ? mem_q_r : 8'd0;
      out_moved       <= res_moved_r;
      out_prior_state <= res_enter_r;
      out_post_state  <= pstate_r;
      out_peer_wakeup <= res_wake_r;
      // queries report occupancy from before any arming
      out_pending     <= 13'(res_query_r ? res_pend_r : pend_cur);
      out_space       <= 13'(res_query_r ? res_space_r : space_cur);
    end
  end

endmodule

### design/shared_buffer_pipe_controller_top.sv
// a request is registered on acceptance, executed, then loaded into the output
//   register once that register is free; the sequencer takes no new request until then
//   (execute includes the registered read of the single-port byte store)
// the next request is taken while a result still waits in the output register
// reset: synchronous active-low; pipe idle, positions zero, both parties present,
//   limit 4096; byte store contents are not cleared
// ----------------------------------------------------------------------------
// shared_buffer_pipe_controller_top
// Byte pipe controller between a writer and a reader over a linear buffer.
// ----------------------------------------------------------------------------
module shared_buffer_pipe_controller_top
  import sbpc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  sbpc_in_if.sink          in_ch,
  sbpc_out_if.source       out_ch,
  input  logic             cfg_we,
  input  logic [LIM_W-1:0] cfg_wdata
);

  sbpc_cmd_t cmd;

  sbpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  sbpc_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_func         (in_ch.func),
    .in_wr_byte      (in_ch.wr_byte),
    .in_arm          (in_ch.arm),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_status      (out_ch.status),
    .out_rd_byte     (out_ch.rd_byte),
    .out_moved       (out_ch.moved),
    .out_prior_state (out_ch.prior_state),
    .out_post_state  (out_ch.post_state),
    .out_peer_wakeup (out_ch.peer_wakeup),
    .out_pending     (out_ch.pending),
    .out_space       (out_ch.space)
  );

endmodule

### design/sbpc_checker.sv
// ----------------------------------------------------------------------------
// sbpc_checker
// Port-level checks for the pipe controller, bound to the top level.
// ----------------------------------------------------------------------------
module sbpc_checker
  import sbpc_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [7:0]  rd_byte,
  input logic        moved,
  input logic [12:0] pending,
  input logic [12:0] space
);

  // a result offered and not taken stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // one request in flight: no request taken right after another
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in flight");

  // a byte only moves on a completed request
  a_moved_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && moved |-> status == ST_COMPLETED)
    else $error("byte moved on a request that did not complete");

  // read data is zero unless a byte moved
  a_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !moved |-> rd_byte == 8'd0)
    else $error("read data without a moved byte");

  // occupancy never exceeds the buffer depth
  a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pending <= 13'(DEPTH)) && (space <= 13'(DEPTH)))
    else $error("pending or space beyond buffer depth");

endmodule

bind shared_buffer_pipe_controller_top sbpc_checker u_sbpc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .status    (out_ch.status),
  .rd_byte   (out_ch.rd_byte),
  .moved     (out_ch.moved),
  .pending   (out_ch.pending),
  .space     (out_ch.space)
);

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the shared buffer pipe controller. A class tracks
// the pipe (state, positions, stored bytes, presence bits, limit) and checks
// every result in order. Short directed runs come first. Then random
// write/read/query phases under a range of buffer limits, and at the end one
// forced close or exit followed by random traffic over all operations. Both
// handshakes are throttled at random, with at most two long output hold-offs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top
  import sbpc_pkg::*;
();

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  rd_byte;
    logic        moved;
    logic [2:0]  prior_state;
    logic [2:0]  post_state;
    logic        peer_wakeup;
    logic [12:0] pending;
    logic [12:0] space;
  } pipe_result_t;

  class pipe_scoreboard;
    pipe_result_t     awaited[$];
    int unsigned      mismatches;
    logic [2:0]       pstate;
    int unsigned      wpos;
    int unsigned      rpos;
    logic [7:0]       stash[DEPTH];
    bit               writer_in;
    bit               reader_in;
    logic [LIM_W-1:0] limit;

    function new();
      mismatches = 0;
      pstate     = PS_IDLE;
      wpos       = 0;
      rpos       = 0;
      writer_in  = 1'b1;
      reader_in  = 1'b1;
      limit      = LIMIT_RESET;
    endfunction

    function void set_limit(logic [LIM_W-1:0] v);
      limit = v;
    endfunction

    function int unsigned free_room();
      int unsigned lim;
      lim = (limit > DEPTH) ? DEPTH : limit;
      return (wpos < lim) ? lim - wpos : 0;
    endfunction

    function int unsigned held_bytes();
      return (wpos >= rpos) ? wpos - rpos : 0;
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction

    function pipe_result_t compute_pipe_result(logic [2:0] fn, logic [7:0] wb, logic ar);
      pipe_result_t r;
      logic [2:0]   enter;
      logic [2:0]   partial;
      int unsigned  room;
      int unsigned  held;
      bit           go;
      bit           as_writer;
      bit           sampled;
      r       = '0;
      enter   = pstate;
      room    = free_room();
      held    = held_bytes();
      go      = 1'b0;
      sampled = 1'b0;
      r.prior_state = enter;
      case (fn)
        FN_WRITE: begin
          if (enter == PS_IDLE || enter == PS_EMPTY_WAIT) begin
            if (room == 0) begin
              pstate   = PS_FULL_WAIT;
              r.status = ST_BLOCKED;
            end else begin
              if (enter == PS_EMPTY_WAIT) pstate = PS_IDLE;
              go = 1'b1;
            end
          end else if (enter == PS_FULL_WAIT) begin
            r.status = ST_BLOCKED;
          end else if (enter == PS_WR_DONE || enter == PS_RD_DONE) begin
            r.status = ST_DISCARDED;
          end else begin
            r.status = ST_ABORT;
          end
          if (go && wpos < DEPTH) begin
            stash[wpos] = wb;
            wpos++;
            r.moved = 1'b1;
          end
          r.peer_wakeup = (r.status == ST_COMPLETED) && (enter == PS_EMPTY_WAIT);
        end
        FN_READ: begin
          if (enter == PS_IDLE) begin
            if (held == 0) begin
              pstate   = PS_EMPTY_WAIT;
              r.status = ST_BLOCKED;
            end else begin
              go = 1'b1;
            end
          end else if (enter == PS_EMPTY_WAIT) begin
            r.status = writer_in ? ST_BLOCKED : ST_DISCARDED;
          end else if (enter == PS_FULL_WAIT) begin
            if (held == 0) pstate = PS_IDLE;
            else go = 1'b1;
          end else if (enter == PS_WR_DONE) begin
            if (held == 0) r.status = ST_DISCARDED;
            else go = 1'b1;
          end else begin
            r.status = ST_ABORT;
          end
          if (go && rpos < DEPTH) begin
            r.rd_byte = stash[rpos];
            rpos++;
            r.moved = 1'b1;
            // drained: both positions go back to the start
            if (rpos == wpos) begin
              rpos = 0;
              wpos = 0;
              if (!writer_in) pstate = PS_WR_DONE;
            end
          end
          r.peer_wakeup = (r.status == ST_COMPLETED) && (enter == PS_FULL_WAIT) &&
                          (pstate == PS_IDLE);
        end
        FN_CLOSE_W, FN_CLOSE_R: begin
          as_writer = (fn == FN_CLOSE_W);
          partial   = as_writer ? PS_WR_DONE : PS_RD_DONE;
          if (as_writer && enter == PS_RD_DONE) partial = PS_CLOSED;
          if (!as_writer && enter == PS_WR_DONE) partial = PS_CLOSED;
          pstate = partial;
          if (enter == PS_FULL_WAIT && !as_writer && writer_in) r.peer_wakeup = 1'b1;
          else if (enter == PS_EMPTY_WAIT && as_writer && reader_in) r.peer_wakeup = 1'b1;
        end
        FN_QUERY_W, FN_QUERY_R: begin
          // occupancy is reported as seen before any arming
          sampled = 1'b1;
          if (enter == PS_IDLE && ar) begin
            if (fn == FN_QUERY_W && room == 0) begin
              pstate = PS_FULL_WAIT;
            end else if (fn == FN_QUERY_R && held == 0) begin
              if (rpos > 0) begin
                rpos = 0;
                wpos = 0;
              end
              pstate = PS_EMPTY_WAIT;
            end
          end
        end
        default: begin
          as_writer = (fn == FN_EXIT_W);
          partial   = as_writer ? PS_WR_DONE : PS_RD_DONE;
          if (as_writer) writer_in = 1'b0;
          else reader_in = 1'b0;
          case (enter)
            PS_IDLE: pstate = partial;
            PS_EMPTY_WAIT: begin
              pstate        = partial;
              r.peer_wakeup = as_writer;
            end
            PS_FULL_WAIT: begin
              pstate        = partial;
              r.peer_wakeup = !as_writer;
            end
            PS_WR_DONE, PS_RD_DONE: begin
              if (enter != partial) pstate = PS_CLOSED;
            end
            default: ;
          endcase
        end
      endcase
      if (!sampled) begin
        room = free_room();
        held = held_bytes();
      end
      r.post_state = pstate;
      r.pending    = held[12:0];
      r.space      = room[12:0];
      return r;
    endfunction

    function void note_request(logic [2:0] fn, logic [7:0] wb, logic ar);
      awaited.push_back(compute_pipe_result(fn, wb, ar));
    endfunction

    function string fmt(pipe_result_t r);
      return $sformatf("st=%0d rd=%02h mv=%0d in=%0d out=%0d wk=%0d pend=%0d sp=%0d",
                       r.status, r.rd_byte, r.moved, r.prior_state, r.post_state,
                       r.peer_wakeup, r.pending, r.space);
    endfunction

    function void check_result(pipe_result_t got);
      pipe_result_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with no request outstanding: %s", fmt(got));
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status || got.rd_byte !== want.rd_byte ||
          got.moved !== want.moved || got.prior_state !== want.prior_state ||
          got.post_state !== want.post_state || got.peer_wakeup !== want.peer_wakeup ||
          got.pending !== want.pending || got.space !== want.space) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch at %0t", $realtime);
          $display("  expected %s", fmt(want));
          $display("  actual   %s", fmt(got));
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [LIM_W-1:0] cfg_wdata;

  sbpc_in_if  in_if();
  sbpc_out_if out_if();

  pipe_scoreboard sb = new();

  int  burst_left;
  bit  random_live;

  shared_buffer_pipe_controller_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    #6000000;
    $display("FAIL shared_buffer_pipe_controller_top");
    $finish;
  end

  // result monitor
  always @(posedge clk) begin
    pipe_result_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.status      = out_if.status;
      got.rd_byte     = out_if.rd_byte;
      got.moved       = out_if.moved;
      got.prior_state = out_if.prior_state;
      got.post_state  = out_if.post_state;
      got.peer_wakeup = out_if.peer_wakeup;
      got.pending     = out_if.pending;
      got.space       = out_if.space;
      sb.check_result(got);
    end
  end

  // receiver: changing stall patterns, plus long hold-offs once traffic is random
  initial begin
    int seg;
    int mode;
    int holds;
    int k;
    out_if.ready <= 1'b0;
    seg   = 0;
    holds = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (random_live && holds < 2 && seg % 40 == 39) begin
        out_if.ready <= 1'b0;
        repeat (400) @(posedge clk);
        holds++;
      end else begin
        mode = $urandom_range(0, 3);
        for (k = 0; k < 32; k++) begin
          case (mode)
            0: out_if.ready <= 1'b1;
            1: out_if.ready <= ($urandom_range(0, 1) == 1);
            2: out_if.ready <= (k % 3 != 2);
            default: out_if.ready <= ($urandom_range(0, 3) == 0);
          endcase
          @(posedge clk);
        end
      end
      seg++;
    end
  end

  task automatic send_op(input logic [2:0] fn, input logic [7:0] wb, input logic ar);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_if.valid   <= 1'b1;
    in_if.func    <= fn;
    in_if.wr_byte <= wb;
    in_if.arm     <= ar;
    do @(posedge clk); while (!in_if.ready);
    sb.note_request(fn, wb, ar);
  endtask

  // let every result come back, then write the limit
  task automatic set_limit_when_idle(input logic [LIM_W-1:0] v);
    in_if.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_limit(v);
  endtask

  function automatic logic [LIM_W-1:0] pick_limit();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return LIM_W'(1);
      2: return LIM_W'($urandom_range(2, 4));
      7: return LIMIT_RESET;
      8: return '1;
      9: return LIM_W'($urandom_range(0, 8191));
      default: return LIM_W'($urandom_range(5, 24));
    endcase
  endfunction

  initial begin
    int live_sent;
    int len;
    int wr_pct;
    int pick;
    int target;
    logic [2:0] escapes[4];
    escapes = '{FN_CLOSE_W, FN_CLOSE_R, FN_EXIT_W, FN_EXIT_R};
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    in_if.valid   <= 1'b0;
    in_if.func    <= FN_WRITE;
    in_if.wr_byte <= '0;
    in_if.arm     <= 1'b0;
    burst_left    = 0;
    random_live   = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty pipe: queries, reader waiting, writer waking it
    send_op(FN_QUERY_W, 8'h00, 1'b0);
    send_op(FN_QUERY_R, 8'hff, 1'b1);
    send_op(FN_READ,    8'h00, 1'b0);
    send_op(FN_QUERY_R, 8'h00, 1'b1);
    send_op(FN_WRITE,   8'h00, 1'b0);
    send_op(FN_WRITE,   8'hff, 1'b1);
    send_op(FN_WRITE,   8'ha5, 1'b0);
    send_op(FN_QUERY_W, 8'h00, 1'b1);
    send_op(FN_READ,    8'h00, 1'b0);
    send_op(FN_READ,    8'h00, 1'b0);
    send_op(FN_WRITE,   8'h5a, 1'b0);

    // limit dropped below the write position
    set_limit_when_idle(LIM_W'(1));
    send_op(FN_WRITE,   8'h11, 1'b0);
    send_op(FN_WRITE,   8'h22, 1'b0);
    send_op(FN_QUERY_W, 8'h00, 1'b1);
    send_op(FN_READ,    8'h00, 1'b0);
    send_op(FN_READ,    8'h00, 1'b0);
    send_op(FN_READ,    8'h00, 1'b0);

    // zero limit: every write blocks
    set_limit_when_idle('0);
    send_op(FN_WRITE,   8'h33, 1'b0);
    send_op(FN_READ,    8'h00, 1'b0);
    send_op(FN_QUERY_W, 8'h00, 1'b1);
    send_op(FN_READ,    8'h00, 1'b0);

    // live traffic: writer and reader both present
    random_live = 1'b1;
    live_sent   = 0;
    while (live_sent < 2000) begin
      set_limit_when_idle(pick_limit());
      len    = $urandom_range(40, 120);
      wr_pct = $urandom_range(30, 70);
      repeat (len) begin
        pick = $urandom_range(0, 99);
        if (pick < 12)
          send_op((pick < 6) ? FN_QUERY_W : FN_QUERY_R, 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
        else if ($urandom_range(0, 99) < wr_pct)
          send_op(FN_WRITE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        else
          send_op(FN_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        live_sent++;
      end
    end

    // steer into idle, reader-wait or writer-wait, then close or exit from there
    set_limit_when_idle(LIM_W'(2));
    target = $urandom_range(0, 2);
    case (target)
      0: begin
        while (sb.pstate == PS_FULL_WAIT) send_op(FN_READ, 8'h00, 1'b0);
        if (sb.pstate == PS_EMPTY_WAIT) send_op(FN_WRITE, 8'h77, 1'b0);
      end
      1: while (sb.pstate != PS_EMPTY_WAIT) send_op(FN_READ, 8'h00, 1'b0);
      default: while (sb.pstate != PS_FULL_WAIT)
        send_op(FN_WRITE, 8'($urandom_range(0, 255)), 1'b0);
    endcase
    send_op(escapes[$urandom_range(0, 3)], 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

    // winding down: every operation at random
    repeat (250)
      send_op(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

    in_if.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0)
      $display("PASS shared_buffer_pipe_controller_top");
    else
      $display("FAIL shared_buffer_pipe_controller_top");
    $finish;
  end

endmodule

### files.f
design/sbpc_pkg.sv
design/sbpc_in_if.sv
design/sbpc_out_if.sv
design/sbpc_ctrl.sv
design/sbpc_dp.sv
design/shared_buffer_pipe_controller_top.sv
design/sbpc_checker.sv
bench/tb_top.sv
